FILE: src/lfg_pkg.sv
// shared constants and helpers for the logit forward and gradient unit
// no dependencies; used by logit_forward_and_gradient and tb_top

package lfg_pkg;

   localparam int FRAC_BITS_DEFAULT = 24;
   localparam int EPS_W             = 23;
   localparam logic [EPS_W-1:0] EPS_RESET = 23'd17;
   localparam int LOG_FRAC          = 28;
   localparam logic [29:0] LN2_Q30  = 30'd744261118;
   localparam int RES_W             = 48;

   typedef enum logic {
      ACT_FORWARD  = 1'b0,
      ACT_GRADIENT = 1'b1
   } action_type;

   typedef struct packed {
      logic [4:0]  expo;
      logic [31:0] mant;
   } norm_type;

   // msb position and left-aligned mantissa of a value below 2^31
   function automatic norm_type log_norm(input logic [31:0] v);
      norm_type n;
      n.expo = '0;
      for (int i = 0; i < 31; i++) begin
         if (v[i]) begin
            n.expo = 5'(i);
         end
      end
      n.mant = v << (5'd31 - n.expo);
      return n;
   endfunction

endpackage

FILE: src/logit_forward_and_gradient.sv
// elementwise logit / logit gradient unit, fully pipelined
// depends on lfg_pkg for constants and the normalise helper

// One request enters per clock and one result leaves per clock while the result
// side is not stalled; both operations run through the same stages.
// The pipe depth is set by the gradient divider, which resolves one quotient bit
// per pipeline stage (32 + 2*FRAC_BITS stages); the forward log2 runs one of its
// 28 squaring steps in each of the first 28 of those stages, with two 32x32
// multiplies (one per log operand) per stage.
// A stall on the result side freezes the whole pipe, so nothing is dropped.
// eps may only be rewritten while no request is in flight.
module logit_forward_and_gradient #(
   parameter int FRAC_BITS = lfg_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [63:0]                  req_tdata,   // x_value[31:0], upstream_grad[63:32]
   input  logic                         req_tuser,   // action
   input  logic                         req_tlast,   // last_item
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [lfg_pkg::RES_W-1:0]    rsp_tdata,   // result_value[47:0]
   output logic                         rsp_tuser,   // saturated
   output logic                         rsp_tlast,   // last_out
   input  logic                         csr_write_enable,
   input  logic [lfg_pkg::EPS_W-1:0]    csr_write_data  // eps
);

   localparam int F    = FRAC_BITS;
   localparam int RW   = 2*F - 1;          // divisor / remainder width
   localparam int NDIV = 32 + 2*F;         // one quotient bit per stage
   localparam int NST  = NDIV + 2;
   localparam int SH   = 30 + lfg_pkg::LOG_FRAC - F;
   localparam logic [63:0] ROUND = 64'd1 << (SH - 1);
   localparam logic [48:0] LIM_POS = 49'h0_7FFF_FFFF_FFFF;
   localparam logic [48:0] LIM_NEG = 49'h0_8000_0000_0000;

   typedef struct packed {
      logic          valid;
      logic          action;
      logic          last;
      // forward path
      logic          f_pos_sat;   // 1 - y not positive
      logic          f_zero_y;    // clamped y is zero
      logic          f_neg;
      logic [31:0]   f_ym;
      logic [31:0]   f_dm;
      logic [32:0]   f_yr;
      logic [32:0]   f_dr;
      logic [63:0]   f_mag;
      // gradient path
      logic          g_zero;      // outside range or dy zero
      logic          g_neg;
      logic [31:0]   g_ady;
      logic [F:0]    g_x;
      logic [F:0]    g_omx;
      logic [RW-1:0] g_p;
      logic [RW-1:0] g_rem;
      logic [48:0]   g_q;
      logic          g_ovf;
   } stage_type;

   typedef struct packed {
      logic [lfg_pkg::RES_W-1:0] val;
      logic                      sat;
   } result_type;

   // clamp, range check and magnitude of dy
   function automatic stage_type stage_entry(input logic vld, input logic [63:0] data,
                                             input logic act, input logic lst,
                                             input logic [lfg_pkg::EPS_W-1:0] ep);
      stage_type n;
      logic signed [32:0] one, e, x, dy, hi, y, d, omx;
      n = '0;
      one = 33'sd1 <<< F;
      e   = $signed({10'b0, ep});
      x   = $signed({data[31], data[31:0]});
      dy  = $signed({data[63], data[63:32]});
      hi  = one - e;
      y   = (x > hi) ? hi : x;
      y   = (y < e) ? e : y;
      d   = one - y;
      omx = one - x;
      n.valid     = vld;
      n.action    = act;
      n.last      = lst;
      n.f_pos_sat = (d <= 33'sd0);
      n.f_zero_y  = (y == 33'sd0);
      n.f_ym      = y[31:0];
      n.f_dm      = d[31:0];
      n.g_zero    = (x < e) || (x > hi) || (dy == 33'sd0);
      n.g_neg     = dy[32];
      n.g_ady     = dy[32] ? 32'(-dy) : dy[31:0];
      n.g_x       = x[F:0];
      n.g_omx     = omx[F:0];
      return n;
   endfunction

   // normalise both log operands, form the divisor x*(1-x)
   function automatic stage_type stage_prep(input stage_type s);
      stage_type n;
      lfg_pkg::norm_type ny, nd;
      logic [2*F+1:0] prod;
      n    = s;
      ny   = lfg_pkg::log_norm(s.f_ym);
      nd   = lfg_pkg::log_norm(s.f_dm);
      prod = s.g_x * s.g_omx;
      n.f_ym  = ny.mant;
      n.f_dm  = nd.mant;
      n.f_yr  = {ny.expo, 28'b0};
      n.f_dr  = {nd.expo, 28'b0};
      n.g_p   = prod[RW-1:0];
      n.g_rem = '0;
      n.g_q   = '0;
      n.g_ovf = 1'b0;
      return n;
   endfunction

   // one divider bit, plus the forward step that belongs to this stage
   function automatic stage_type stage_step(input stage_type s, input int k);
      stage_type n;
      logic          b, ge;
      logic [RW-1:0] shv;
      logic [63:0]   py, pd;
      logic [32:0]   ty, td, mag;
      logic [33:0]   diff;
      n   = s;
      b   = 1'b0;
      if (k < 32) begin
         b = s.g_ady[5'(31 - k)];
      end
      shv = {s.g_rem[RW-2:0], b};
      ge  = (shv >= s.g_p);
      n.g_rem = ge ? (shv - s.g_p) : shv;
      n.g_q   = {s.g_q[47:0], ge};
      n.g_ovf = s.g_ovf | s.g_q[48];
      if (k < lfg_pkg::LOG_FRAC) begin
         py = s.f_ym * s.f_ym;
         pd = s.f_dm * s.f_dm;
         ty = py[63:31];
         td = pd[63:31];
         n.f_ym = ty[32] ? ty[32:1] : ty[31:0];
         n.f_dm = td[32] ? td[32:1] : td[31:0];
         if (ty[32]) begin
            n.f_yr[6'(lfg_pkg::LOG_FRAC - 1 - k)] = 1'b1;
         end
         if (td[32]) begin
            n.f_dr[6'(lfg_pkg::LOG_FRAC - 1 - k)] = 1'b1;
         end
      end else if (k == lfg_pkg::LOG_FRAC) begin
         diff    = {1'b0, s.f_yr} - {1'b0, s.f_dr};
         mag     = diff[33] ? 33'(-diff) : diff[32:0];
         n.f_neg = diff[33];
         n.f_mag = {31'b0, mag};
      end else if (k == lfg_pkg::LOG_FRAC + 1) begin
         n.f_mag = 64'(s.f_mag[32:0] * lfg_pkg::LN2_Q30);
      end else if (k == lfg_pkg::LOG_FRAC + 2) begin
         n.f_mag = (s.f_mag + ROUND) >> SH;
      end
      return n;
   endfunction

   // pick and saturate the result of the finished item
   function automatic result_type result_of(input stage_type s);
      result_type r;
      logic [48:0] limit;
      logic [47:0] mag;
      r = '0;
      if (s.action == lfg_pkg::ACT_FORWARD) begin
         if (s.f_pos_sat) begin
            r.val = 48'h7FFF_FFFF_FFFF;
            r.sat = 1'b1;
         end else if (s.f_zero_y) begin
            r.val = 48'h8000_0000_0000;
            r.sat = 1'b1;
         end else begin
            r.val = s.f_neg ? -s.f_mag[47:0] : s.f_mag[47:0];
         end
      end else if (!s.g_zero) begin
         limit = s.g_neg ? LIM_NEG : LIM_POS;
         r.sat = s.g_ovf | (s.g_q > limit);
         mag   = r.sat ? limit[47:0] : s.g_q[47:0];
         r.val = s.g_neg ? -mag : mag;
      end
      return r;
   endfunction

   // pipeline and output register
   stage_type  pipe_ff [NST];
   stage_type  pipe_in [NST];
   result_type res_in;
   logic [lfg_pkg::EPS_W-1:0]  eps_ff;
   logic                       rsp_valid_ff;
   logic [lfg_pkg::RES_W-1:0]  rsp_data_ff;
   logic                       rsp_sat_ff;
   logic                       rsp_last_ff;
   logic                       adv;

   // whole pipe moves when the output register is free or being drained
   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;

   assign pipe_in[0] = stage_entry(req_tvalid, req_tdata, req_tuser, req_tlast, eps_ff);
   assign pipe_in[1] = stage_prep(pipe_ff[0]);

   for (genvar k = 0; k < NDIV; k++) begin : g_div
      assign pipe_in[k+2] = stage_step(pipe_ff[k+1], k);
   end

   assign res_in = result_of(pipe_ff[NST-1]);

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff       <= lfg_pkg::EPS_RESET;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < NST; k++) begin
            pipe_ff[k].valid <= 1'b0;
         end
      end else begin
         if (csr_write_enable) begin
            eps_ff <= csr_write_data;
         end
         if (adv) begin
            for (int k = 0; k < NST; k++) begin
               pipe_ff[k] <= pipe_in[k];
            end
            rsp_valid_ff <= pipe_ff[NST-1].valid;
            rsp_data_ff  <= res_in.val;
            rsp_sat_ff   <= res_in.sat;
            rsp_last_ff  <= pipe_ff[NST-1].last;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_sat_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("request taken while result stalled");

   a_pipe_to_out: assert property (@(posedge clock) disable iff (reset)
      (adv && pipe_ff[NST-1].valid) |=> rsp_tvalid)
      else $error("finished item lost at output register");

   a_grad_zero: assert property (@(posedge clock) disable iff (reset)
      $past(!reset && adv && pipe_ff[NST-1].valid && pipe_ff[NST-1].action
            && pipe_ff[NST-1].g_zero) |-> (rsp_tdata == '0 && !rsp_tuser))
      else $error("out-of-range gradient not zero");
`endif

endmodule

FILE: sim/tb_top.sv
// self-checking testbench for the logit forward and gradient unit
// depends on lfg_pkg and logit_forward_and_gradient; stand-alone, no files read
`timescale 1ns / 100ps

// scoreboard: predicts each result from the accepted request and the current eps
class logit_scoreboard;
   logic [22:0] eps = lfg_pkg::EPS_RESET;
   logic [47:0] exp_value[$];
   logic        exp_sat[$];
   logic        exp_last[$];
   int          fails = 0;

   // log2 with 28 fraction bits, truncating at every squaring step
   function automatic longint unsigned log2_q28(longint unsigned v);
      int e;
      longint unsigned t, m, r;
      e = 0;
      t = v;
      while (t > 1) begin
         t = t >> 1;
         e++;
      end
      m = v << (31 - e);
      r = longint'(e) << 28;
      for (int i = 27; i >= 0; i--) begin
         m = (m * m) >> 31;
         if (m >= 64'h1_0000_0000) begin
            m = m >> 1;
            r = r | (64'd1 << i);
         end
      end
      return r;
   endfunction

   function void note_request(lfg_pkg::action_type act, logic [31:0] xv,
                              logic [31:0] dyv, logic lst);
      longint one, e, x, dy, y, d, diff, val;
      longint unsigned mag, ady, lim, p, rem, q, b;
      logic sat;
      one = 64'sd1 << 24;
      e = longint'(eps);
      x = longint'(signed'(xv));
      dy = longint'(signed'(dyv));
      val = 0;
      sat = 0;
      if (act == lfg_pkg::ACT_FORWARD) begin
         y = x;
         if (y > one - e) y = one - e;
         if (y < e) y = e;
         d = one - y;
         if (d <= 0) begin
            val = 64'sh7FFF_FFFF_FFFF;
            sat = 1;
         end else if (y == 0) begin
            val = -64'sh8000_0000_0000;
            sat = 1;
         end else begin
            diff = longint'(log2_q28(y)) - longint'(log2_q28(d));
            mag = (diff < 0) ? -diff : diff;
            mag = mag * 744261118;
            mag = (mag + (64'd1 << 33)) >> 34;
            val = (diff < 0) ? -longint'(mag) : longint'(mag);
         end
      end else if (!(x < e || x > one - e) && dy != 0) begin
         // gradient inside the clamp range: long division on magnitudes
         ady = (dy < 0) ? -dy : dy;
         lim = (dy < 0) ? 64'h8000_0000_0000 : 64'h7FFF_FFFF_FFFF;
         p = x * (one - x);
         if (p == 0) begin
            q = lim;
            sat = 1;
         end else begin
            rem = 0;
            q = 0;
            for (int i = 79; i >= 0; i--) begin
               b = (i >= 48) ? ((ady >> (i - 48)) & 1) : 0;
               rem = (rem << 1) | b;
               q = q << 1;
               if (rem >= p) begin
                  rem = rem - p;
                  q = q | 1;
               end
               if (q > lim) begin
                  q = lim;
                  sat = 1;
                  break;
               end
            end
         end
         val = (dy < 0) ? -longint'(q) : longint'(q);
      end
      exp_value.push_back(val[47:0]);
      exp_sat.push_back(sat);
      exp_last.push_back(lst);
   endfunction

   function void check_result(logic [47:0] v, logic s, logic l);
      if (exp_value.size() == 0) begin
         $error("result with nothing expected: value %h", v);
         fails++;
         return;
      end
      if (v !== exp_value[0]) begin
         $error("result_value expected %h actual %h", exp_value[0], v);
         fails++;
      end
      if (s !== exp_sat[0]) begin
         $error("saturated expected %b actual %b", exp_sat[0], s);
         fails++;
      end
      if (l !== exp_last[0]) begin
         $error("last_out expected %b actual %b", exp_last[0], l);
         fails++;
      end
      void'(exp_value.pop_front());
      void'(exp_sat.pop_front());
      void'(exp_last.pop_front());
   endfunction
endclass

module tb_top;
   localparam int LATENCY = 83;
   localparam int STALL_LIMIT = 2000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;    // x_value[31:0], upstream_grad[63:32]
   logic        req_tuser = 0;     // action
   logic        req_tlast = 0;     // last_item
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [47:0] rsp_tdata;         // result_value[47:0]
   logic        rsp_tuser;         // saturated
   logic        rsp_tlast;         // last_out
   logic        csr_write_enable = 0;
   logic [22:0] csr_write_data = '0;

   logit_scoreboard board = new();
   logic stim_done = 0;
   int   idle_cycles = 0;

   always #2 clock = ~clock;

   logit_forward_and_gradient DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   // results are checked at the edge that accepts them
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         board.check_result(rsp_tdata, rsp_tuser, rsp_tlast);
      end
   end

   // watchdog on cycles with no request or result moving
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles > STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // receiver: random stalls, with calm stretches
   initial begin : sink
      int gap;
      int calm;
      calm = 0;
      @(posedge clock);
      forever begin
         if (calm > 0) begin
            gap = 0;
            calm--;
         end else begin
            gap = $urandom_range(0, 19);
            if ($urandom_range(0, 15) == 0) calm = $urandom_range(20, 80);
         end
         if (gap > 0) begin
            rsp_tready <= 0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   int send_calm = 0;

   // sends one request, with a random hold-off before it
   task automatic send_request(lfg_pkg::action_type act, logic [31:0] xv,
                               logic [31:0] dyv, logic lst);
      int gap;
      if (send_calm > 0) begin
         gap = 0;
         send_calm--;
      end else begin
         gap = $urandom_range(0, 19);
         if ($urandom_range(0, 15) == 0) send_calm = $urandom_range(20, 80);
      end
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= {dyv, xv};
      req_tuser  <= act;
      req_tlast  <= lst;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(act, xv, dyv, lst);
   endtask

   // waits for the pipe to drain, then writes eps
   task automatic write_eps(logic [22:0] value);
      req_tvalid <= 0;
      @(posedge clock);
      while (board.exp_value.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
      csr_write_enable <= 1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 0;
      board.eps = value;
   endtask

   // x biased towards the interesting window [0, 1] and its edges
   function automatic logic [31:0] pick_x(logic [22:0] e);
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return $urandom_range(0, 32'h0100_0000);
         2: return e + $urandom_range(0, 3) - 2;
         3: return 32'h0100_0000 - e + $urandom_range(0, 3) - 1;
         4: return $urandom_range(0, 64);
         default: return 32'h0100_0000 - $urandom_range(0, 64);
      endcase
   endfunction

   task automatic random_phase(int count);
      logic [31:0] dy;
      for (int i = 0; i < count; i++) begin
         dy = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) - 2 : $urandom;
         send_request(lfg_pkg::action_type'($urandom_range(0, 1)), pick_x(board.eps),
                      dy, 1'($urandom_range(0, 1)));
      end
   endtask

   initial begin : stimulus
      logic [22:0] eps_set[5];
      eps_set = '{23'd1, 23'h7F_FFFF, 23'd4096, 23'h40_0000, 23'd0};
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: field extremes, both operations, clamp edges, tiny and huge dy
      send_request(lfg_pkg::ACT_FORWARD, 32'h8000_0000, 32'h0, 0);
      send_request(lfg_pkg::ACT_FORWARD, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1);
      send_request(lfg_pkg::ACT_FORWARD, 32'h0080_0000, 32'h0, 0);
      send_request(lfg_pkg::ACT_FORWARD, 32'd17, 32'h0, 0);
      send_request(lfg_pkg::ACT_FORWARD, 32'h00FF_FFEF, 32'h0, 1);
      send_request(lfg_pkg::ACT_FORWARD, 32'h0, 32'h0, 0);
      send_request(lfg_pkg::ACT_GRADIENT, 32'h0080_0000, 32'h7FFF_FFFF, 0);
      send_request(lfg_pkg::ACT_GRADIENT, 32'h0080_0000, 32'h8000_0000, 1);
      send_request(lfg_pkg::ACT_GRADIENT, 32'd17, 32'h7FFF_FFFF, 0);
      send_request(lfg_pkg::ACT_GRADIENT, 32'd17, 32'h8000_0000, 0);
      send_request(lfg_pkg::ACT_GRADIENT, 32'd16, 32'h0100_0000, 0);
      send_request(lfg_pkg::ACT_GRADIENT, 32'h00FF_FFF0, 32'h0100_0000, 1);
      send_request(lfg_pkg::ACT_GRADIENT, 32'h0040_0000, 32'h0, 0);
      send_request(lfg_pkg::ACT_GRADIENT, 32'h0040_0000, 32'd1, 0);
      send_request(lfg_pkg::ACT_GRADIENT, 32'h8000_0000, 32'hFFFF_FFFF, 1);
      random_phase(300);

      // eps sweep: smallest, just below one half (narrow range), 2^-12, one quarter, zero
      foreach (eps_set[k]) begin
         write_eps(eps_set[k]);
         // zero divisor and zero numerator edges matter most with eps at zero
         send_request(lfg_pkg::ACT_GRADIENT, 32'h0, 32'h0000_1000, 0);
         send_request(lfg_pkg::ACT_GRADIENT, 32'h0100_0000, 32'hFFFF_F000, 0);
         send_request(lfg_pkg::ACT_GRADIENT, 32'h0, 32'h0, 0);
         send_request(lfg_pkg::ACT_FORWARD, 32'hFFFF_FFFF, 32'h0, 1);
         random_phase(130);
      end
      write_eps(23'($urandom_range(1, 23'h7F_FFFF)));
      random_phase(50);

      req_tvalid <= 0;
      stim_done <= 1;
   end

   initial begin : finish_up
      int waited;
      waited = 0;
      wait (stim_done);
      while (board.exp_value.size() != 0) @(posedge clock);
      // extra cycles to catch stray results
      while (waited < 2 * LATENCY) begin
         @(posedge clock);
         waited++;
      end
      if (board.fails == 0 && board.exp_value.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
